// ----- hw/rtl/jcs_pkg.sv -----
// Shared types and character constants for the JSON comment stripper.
// No dependencies; imported by the top level, jcs_scan, jcs_obuf and the testbench.
`default_nettype none

package jcs_pkg;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef enum logic [2:0] {
		MODE_TEXT       = 3'd0,
		MODE_STR        = 3'd1,
		MODE_STR_ESC    = 3'd2,
		MODE_LINE       = 3'd3,
		MODE_BLOCK      = 3'd4,
		MODE_BLOCK_STAR = 3'd5
	} scan_mode_t;

	// scanner state carried from one byte to the next
	typedef struct packed {
		scan_mode_t mode;
		logic       held;   // a slash waits for its lookahead byte
	} scan_state_t;

	// up to two output words produced by one input word
	typedef struct packed {
		logic [1:0] count;
		logic [7:0] data0;
		logic       last0;
		logic [7:0] data1;
		logic       last1;
	} scan_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/json_comment_stripper_unit.sv -----
// JSON comment stripper, top level: input register, scanner state, output pair.
// Uses jcs_pkg, jcs_scan and jcs_obuf.
//
// Streams JSON text one byte per word and returns the same text with // and
// /* */ comments replaced by spaces; newlines ending line comments are kept,
// quoted strings (with backslash escapes) pass untouched. s_tlast marks the
// last byte of a text and m_tlast the last byte returned for it; the scanner
// returns to plain-text state after every text. A slash is held one byte for
// lookahead, so an input word yields zero, one or two output words. The block
// accepts one input word per cycle unless the output side stalls; output is
// one word per cycle while m_tready is high, from a two-entry output register,
// so a word that yields two outputs slows intake. Words pass the input register,
// then the output register. No configuration; reset is asynchronous, active low.
`default_nettype none

module json_comment_stripper_unit
	import jcs_pkg::*;
(
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [7:0]  s_tdata,   // [7:0] in_byte
	input  wire        s_tlast,   // is_last
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast    // last_out
);

	// input register
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;

	// scanner state, advanced once per processed word
	scan_state_t state_q;
	scan_state_t state_nxt;
	scan_res_t   res;
	logic        can_load;
	logic        proc;

	assign proc     = valid_s1 && can_load;
	assign s_tready = !valid_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode <= MODE_TEXT;
			state_q.held <= 1'b0;
		end else if (proc) begin
			state_q <= state_nxt;
		end
	end

	jcs_scan u_scan (
		.cur     (state_q),
		.in_byte (data_s1),
		.is_last (last_s1),
		.nxt     (state_nxt),
		.res     (res)
	);

	jcs_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (proc),
		.res      (res),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/jcs_scan.sv -----
// Combinational scanner: one input byte plus current state gives next state
// and zero to two output words. Depends on jcs_pkg.
`default_nettype none

module jcs_scan
	import jcs_pkg::*;
(
	input  wire scan_state_t cur,
	input  wire logic [7:0]  in_byte,
	input  wire logic        is_last,
	output scan_state_t      nxt,
	output scan_res_t        res
);

	always_comb begin
		logic [1:0] n;
		logic       consumed;
		logic       emit;
		logic [7:0] val;
		scan_mode_t nm;
		logic       nh;

		n        = 2'd0;
		consumed = 1'b0;
		emit     = 1'b0;
		val      = in_byte;
		nm       = cur.mode;
		nh       = 1'b0;
		res      = '0;

		// pending slash resolves first
		if (cur.held) begin
			if (in_byte == CH_SLASH || in_byte == CH_STAR) begin
				res.data0 = CH_SPACE;
				res.data1 = CH_SPACE;
				n         = 2'd2;
				nm        = (in_byte == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
				consumed  = 1'b1;
			end else begin
				res.data0 = CH_SLASH;
				n         = 2'd1;
			end
		end

		if (!consumed) begin
			case (cur.mode)
				MODE_STR: begin
					emit = 1'b1;
					if (in_byte == CH_QUOTE)
						nm = MODE_TEXT;
					else if (in_byte == CH_BSLASH)
						nm = MODE_STR_ESC;
				end
				MODE_STR_ESC: begin
					emit = 1'b1;
					nm   = MODE_STR;
				end
				MODE_LINE: begin
					emit = 1'b1;
					if (in_byte == CH_NL)
						nm = MODE_TEXT;
					else
						val = CH_SPACE;
				end
				MODE_BLOCK: begin
					emit = 1'b1;
					val  = CH_SPACE;
					if (in_byte == CH_STAR)
						nm = MODE_BLOCK_STAR;
				end
				MODE_BLOCK_STAR: begin
					emit = 1'b1;
					val  = CH_SPACE;
					if (in_byte == CH_SLASH)
						nm = MODE_TEXT;
					else if (in_byte != CH_STAR)
						nm = MODE_BLOCK;
				end
				default: begin
					nm = MODE_TEXT;
					if (in_byte == CH_QUOTE) begin
						emit = 1'b1;
						nm   = MODE_STR;
					end else if (in_byte == CH_SLASH) begin
						nh = 1'b1;
					end else begin
						emit = 1'b1;
					end
				end
			endcase
		end

		if (emit) begin
			if (n == 2'd0)
				res.data0 = val;
			else
				res.data1 = val;
			n = n + 2'd1;
		end

		// end of text: flush a held slash, then back to reset state
		if (is_last) begin
			if (nh) begin
				if (n == 2'd0)
					res.data0 = CH_SLASH;
				else
					res.data1 = CH_SLASH;
				n = n + 2'd1;
			end
			nh = 1'b0;
			nm = MODE_TEXT;
		end

		res.count = n;
		res.last0 = is_last && (n == 2'd1);
		res.last1 = is_last && (n == 2'd2);
		nxt.mode  = nm;
		nxt.held  = nh;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/jcs_obuf.sv -----
// Two-entry output register: loads a pair of words from the scanner and
// presents them one per cycle while m_tready is high on the master stream. Depends on jcs_pkg.
`default_nettype none

module jcs_obuf
	import jcs_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	input  wire logic        load,      // scanner result taken this cycle
	input  wire scan_res_t   res,
	output logic             can_load,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [7:0] out_byte
	output logic             m_tlast    // last_out
);

	logic [1:0] cnt_q;
	logic [7:0] data0_q, data1_q;
	logic       last0_q, last1_q;
	logic       pop;

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = data0_q;
	assign m_tlast  = last0_q;
	assign pop      = m_tvalid && m_tready;
	// room for a new pair once the head slot drains
	assign can_load = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load && res.count != 2'd0) begin
			cnt_q <= res.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res.count != 2'd0) begin
			data0_q <= res.data0;
			last0_q <= res.last0;
			data1_q <= res.data1;
			last1_q <= res.last1;
		end else if (pop) begin
			data0_q <= data1_q;
			last0_q <= last1_q;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/jcs_checker.sv -----
// Port-level checker for json_comment_stripper_unit, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none

module jcs_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       s_tvalid,
	input wire       s_tready,
	input wire       s_tlast,
	input wire       m_tvalid,
	input wire       m_tready,
	input wire [7:0] m_tdata,
	input wire       m_tlast
);

	logic       seen_q;     // some word accepted since reset
	logic [2:0] frames_q;   // texts taken in but not yet closed on output

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q   <= 1'b0;
			frames_q <= 3'd0;
		end else begin
			if (s_tvalid && s_tready)
				seen_q <= 1'b1;
			frames_q <= frames_q
				+ {2'b00, s_tvalid && s_tready && s_tlast}
				- {2'b00, m_tvalid && m_tready && m_tlast};
		end
	end

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	// nothing comes out before something went in
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> seen_q)
		else $error("output word without any input");

	// empty output side never blocks intake
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with output empty");

	// a text end on output needs a text end taken in
	a_last_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |-> frames_q != 3'd0)
		else $error("last output word without matching last input word");

endmodule

bind json_comment_stripper_unit jcs_checker u_jcs_checker (.*);

`default_nettype wire

// ----- dv/json_comment_stripper_unit_tb.sv -----
// Self-checking testbench for json_comment_stripper_unit: directed and random JSON texts,
// predicted word by word against an in-bench scanner model. Depends on jcs_pkg and the DUT.
`timescale 1ns / 100ps

module json_comment_stripper_unit_tb;
	import jcs_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int unsigned RAND_WORDS  = 2000;

	// one output word as the scanner should produce it
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} strip_word_t;

	// one input word waiting to be sent
	typedef struct {
		logic [7:0]  data;
		logic        last;
		bit          drain;   // hold off until every expected word is back
		int unsigned gap;     // idle cycles before this word
	} feed_word_t;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = '0;   // [7:0] in_byte
	logic       s_tlast  = 1'b0; // is_last
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;         // [7:0] out_byte
	logic       m_tlast;         // last_out

	feed_word_t  feed_q[$];
	strip_word_t strip_expect[$];
	logic [7:0]  text_buf[$];

	// predictor state, mirrors the scanner
	scan_mode_t pred_mode = MODE_TEXT;
	bit         pred_held = 1'b0;

	int unsigned src_level = 0;   // percent of words preceded by a gap
	int unsigned dst_level = 0;   // percent of cycles that start a stall
	int unsigned stall_left = 0;
	int unsigned cycle_count = 0;
	int unsigned words_in = 0, words_out = 0, mismatch_count = 0;
	int unsigned text_count = 0, drain_count = 0, queued_words = 0;
	strip_word_t exp_w;

	string plain_set = "{}[],:0123456789 abefnlrstu\t\r\n-.";

	json_comment_stripper_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// mostly short idles, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	// -------------------------------------------------------------------------
	// Scanner prediction: one input word in, zero to two output words queued.
	// -------------------------------------------------------------------------
	task automatic predict_strip(input logic [7:0] b, input logic last);
		strip_word_t res[$];
		bit          taken;
		taken = 1'b0;

		// a held slash resolves on this byte: comment opener or plain slash
		if (pred_held) begin
			pred_held = 1'b0;
			if (b == CH_SLASH || b == CH_STAR) begin
				res.push_back('{CH_SPACE, 1'b0});
				res.push_back('{CH_SPACE, 1'b0});
				if (b == CH_SLASH)
					pred_mode = MODE_LINE;
				else
					pred_mode = MODE_BLOCK;
				taken = 1'b1;
			end else begin
				res.push_back('{CH_SLASH, 1'b0});
			end
		end

		if (!taken) begin
			case (pred_mode)
				MODE_STR: begin
					if (b == CH_QUOTE)
						pred_mode = MODE_TEXT;
					else if (b == CH_BSLASH)
						pred_mode = MODE_STR_ESC;
					res.push_back('{b, 1'b0});
				end
				MODE_STR_ESC: begin
					res.push_back('{b, 1'b0});
					pred_mode = MODE_STR;
				end
				MODE_LINE: begin
					// newline survives and ends the comment
					if (b == CH_NL) begin
						res.push_back('{CH_NL, 1'b0});
						pred_mode = MODE_TEXT;
					end else begin
						res.push_back('{CH_SPACE, 1'b0});
					end
				end
				MODE_BLOCK: begin
					res.push_back('{CH_SPACE, 1'b0});
					if (b == CH_STAR)
						pred_mode = MODE_BLOCK_STAR;
				end
				MODE_BLOCK_STAR: begin
					res.push_back('{CH_SPACE, 1'b0});
					if (b == CH_SLASH)
						pred_mode = MODE_TEXT;
					else if (b != CH_STAR)
						pred_mode = MODE_BLOCK;
				end
				default: begin
					pred_mode = MODE_TEXT;
					if (b == CH_QUOTE) begin
						res.push_back('{b, 1'b0});
						pred_mode = MODE_STR;
					end else if (b == CH_SLASH) begin
						pred_held = 1'b1;
					end else begin
						res.push_back('{b, 1'b0});
					end
				end
			endcase
		end

		// end of text: flush a pending slash, tag the final word, start over
		if (last) begin
			if (pred_held)
				res.push_back('{CH_SLASH, 1'b0});
			if (res.size() > 0)
				res[res.size() - 1].last = 1'b1;
			pred_mode = MODE_TEXT;
			pred_held = 1'b0;
		end

		foreach (res[i])
			strip_expect.push_back(res[i]);
	endtask

	// -------------------------------------------------------------------------
	// Stimulus construction
	// -------------------------------------------------------------------------

	// send text_buf as one text, tlast on its final byte
	task automatic queue_text(input bit drain);
		feed_word_t w;
		foreach (text_buf[i]) begin
			w.data  = text_buf[i];
			w.last  = (i == text_buf.size() - 1);
			w.drain = drain && (i == 0);
			w.gap   = ($urandom_range(0, 99) < src_level) ? pick_gap() : 0;
			feed_q.push_back(w);
		end
		queued_words += text_buf.size();
		text_count++;
		if (drain)
			drain_count++;
		text_buf.delete();
	endtask

	task automatic queue_string(input string s);
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
		queue_text(1'b0);
	endtask

	function automatic logic [7:0] plain_byte();
		return plain_set[$urandom_range(0, plain_set.len() - 1)];
	endfunction

	// body byte for strings and comments, biased toward the interesting ones
	function automatic logic [7:0] body_byte();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return CH_STAR;
		else if (r < 22)
			return CH_SLASH;
		else if (r < 26)
			return CH_NL;
		else if (r < 34)
			return 8'($urandom_range(0, 255));
		return plain_byte();
	endfunction

	// one JSON-with-comments token appended to text_buf
	task automatic add_token();
		int unsigned r, n;
		logic [7:0]  c;
		r = $urandom_range(0, 99);
		n = $urandom_range(0, 6);
		if (r < 30) begin
			repeat (n + 1)
				text_buf.push_back(plain_byte());
		end else if (r < 52) begin
			text_buf.push_back(CH_QUOTE);
			repeat (n) begin
				c = body_byte();
				if (c == CH_QUOTE || c == CH_BSLASH || $urandom_range(0, 9) == 0)
					text_buf.push_back(CH_BSLASH);
				text_buf.push_back(c);
			end
			if ($urandom_range(0, 9) != 0)
				text_buf.push_back(CH_QUOTE);
		end else if (r < 66) begin
			text_buf.push_back(CH_SLASH);
			text_buf.push_back(CH_SLASH);
			repeat (n)
				text_buf.push_back(body_byte());
			text_buf.push_back(CH_NL);
		end else if (r < 82) begin
			text_buf.push_back(CH_SLASH);
			text_buf.push_back(CH_STAR);
			repeat (n)
				text_buf.push_back(body_byte());
			text_buf.push_back(CH_STAR);
			text_buf.push_back(CH_SLASH);
		end else if (r < 90) begin
			// lone slash followed by something that does not open a comment
			text_buf.push_back(CH_SLASH);
			text_buf.push_back(plain_byte());
		end else begin
			repeat (n + 1)
				text_buf.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// -------------------------------------------------------------------------
	// Driver: presents feed_q words, honoring gaps and drain requests
	// -------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (feed_q.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (feed_q[0].gap != 0) begin
				feed_q[0].gap--;
				s_tvalid <= 1'b0;
			end else if (feed_q[0].drain && (s_tvalid || strip_expect.size() != 0)) begin
				// let the block run dry before the next text
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata  <= feed_q[0].data;
				s_tlast  <= feed_q[0].last;
				void'(feed_q.pop_front());
			end
		end
	end

	// Sink: random stalls, level redrawn from the cycle counter below (zero means no stalls)
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 99) < dst_level)
				stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count % 500 == 0)
			case ($urandom_range(0, 3))
				0: dst_level = 0;
				1: dst_level = 10;
				2: dst_level = 35;
				default: dst_level = 70;
			endcase
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected",
				cycle_count, strip_expect.size());
			$display("simulation failed");
			$finish;
		end
	end

	// -------------------------------------------------------------------------
	// Monitor: predict on accepted input words, then check accepted outputs.
	// Output lags input by the input and output registers, so prediction first is safe.
	// -------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				words_in++;
				predict_strip(s_tdata, s_tlast);
			end
			if (m_tvalid && m_tready) begin
				words_out++;
				if (strip_expect.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected output word: data=%h last=%b",
							m_tdata, m_tlast);
				end else begin
					exp_w = strip_expect.pop_front();
					if (m_tdata !== exp_w.data || m_tlast !== exp_w.last) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch at output word %0d: expected data=%h last=%b, got data=%h last=%b",
								words_out, exp_w.data, exp_w.last, m_tdata, m_tlast);
					end
				end
			end
		end
	end

	// -------------------------------------------------------------------------
	// Test sequence
	// -------------------------------------------------------------------------
	initial begin
		// directed texts
		queue_string("/x");                       // held slash then plain byte
		queue_string("//a\n");                    // line comment keeps newline
		queue_string("/*/*/");                    // slash after opener does not close
		queue_string({"\"\\\"", "\\"});           // escaped quote, backslash at end
		text_buf.push_back(8'h00);                // zero and all-ones as plain bytes,
		text_buf.push_back(8'hFF);                // slash flushed at end of text
		text_buf.push_back(CH_SLASH);
		queue_text(1'b0);
		queue_string("/*");                       // unclosed block comment
		queue_string("/");                        // text of one held slash

		// random texts: mostly well-formed token runs, some cut short
		while (queued_words < RAND_WORDS + 25) begin
			if (text_count % 10 == 0)
				case ($urandom_range(0, 3))
					0: src_level = 0;
					1: src_level = 10;
					2: src_level = 30;
					default: src_level = 70;
				endcase
			repeat (($urandom_range(0, 19) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 8))
				add_token();
			if ($urandom_range(0, 6) == 0)
				while (text_buf.size() > 1 && $urandom_range(0, 3) != 0)
					void'(text_buf.pop_back());
			queue_text(drain_count == 0 || $urandom_range(0, 19) == 0);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (feed_q.size() != 0 || s_tvalid);
		while (strip_expect.size() != 0)
			@(posedge clk);
		// input and output registers; anything extra that shows up is flagged by the monitor
		repeat (20) @(posedge clk);

		$display("%0d texts (%0d drained first), %0d words in, %0d words out, %0d mismatches",
			text_count, drain_count, words_in, words_out, mismatch_count);
		$display("covered strings with escapes, line and block comments, held slashes, truncated texts");
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
